// File: src/hdlc_pkg.sv
// ----------------------------------------------------------------------------
// HDLC deframer package
// Result codes, result entry type and the CRC-16/X.25 nibble helpers.
// ----------------------------------------------------------------------------
package hdlc_pkg;

	// Result kinds, carried on m_tuser
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_GOOD  = 2'd1;
	localparam logic [1:0] KIND_BAD   = 2'd2;
	localparam logic [1:0] KIND_ABORT = 2'd3;

	// CRC-16/X.25, reflected, table-free nibble form
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_NIBBLE_STEP = 16'h1081;

	// Bit stuffing run lengths
	localparam logic [2:0] STUFF_RUN = 3'd5;
	localparam logic [2:0] FLAG_RUN  = 3'd6;

	// Result queue depth (two results may arrive per item)
	localparam int RQ_DEPTH = 4;

	typedef struct packed {
		logic       last;
		logic [1:0] kind;
		logic [7:0] data;
	} res_t;

	// One nibble step of the reflected CRC
	function automatic logic [15:0] crc_nibble(input logic [15:0] c, input logic [3:0] nib);
		logic [3:0] idx;
		idx = c[3:0] ^ nib;
		return (c >> 4) ^ 16'(16'(idx) * CRC_NIBBLE_STEP);
	endfunction

	// A byte is two nibble steps, low nibble first
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] t;
		t = crc_nibble(c, b[3:0]);
		return crc_nibble(t, b[7:4]);
	endfunction

endpackage

// File: src/hdlc_nrzi_deframer_crc16.sv
// ----------------------------------------------------------------------------
// HDLC NRZI deframer with CRC-16 FCS check
// NRZI decode, destuffing, flag/abort detection, byte packing and FCS check.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*): one item per handshake, eight sliced line bits,
//   oldest bit in bit 7. Master channel (m_*): result items, each either a
//   decoded frame byte (m_tuser = data) or a frame status (good, bad FCS or
//   short, aborted); m_tlast marks the final result caused by one input item.
//   Frame bytes come out two bytes late, so the two FCS bytes never appear
//   as data.
//   An accepted item waits in the input register until the queue has room;
//   the decode stage then writes its results into the queue, and m_tvalid
//   is driven from the registered queue count.
//   Throughput: one item per cycle while the queue has room; the eight bit
//   steps and the two CRC nibble steps for the released byte sit in the
//   single decode stage.
//   Results wait in a four-entry queue; the decode stage moves only when two
//   entries are free. When the receiver stalls, items keep flowing until
//   three or more results wait; the item in the input register then holds
//   and s_tready drops.
//   Reset: clears the line state, closes any frame and empties the queue.
// ----------------------------------------------------------------------------
module hdlc_nrzi_deframer_crc16 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] line_bits
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] data_byte
	output logic [1:0] m_tuser,   // [1:0] kind
	output logic       m_tlast    // last
);
	import hdlc_pkg::*;

	localparam int PTR_W = $clog2(RQ_DEPTH);
	localparam int CNT_W = $clog2(RQ_DEPTH + 1);

	// Input stage
	logic       s1_valid_q;
	logic [7:0] line_s1;
	logic       adv;

	// Decoder state
	logic        prev_q;
	logic [2:0]  ones_q;
	logic [7:0]  pbyte_q;
	logic [3:0]  ppos_q;
	logic        open_q;
	logic [7:0]  hb0_q;
	logic [7:0]  hb1_q;
	logic [1:0]  fcnt_q;
	logic [15:0] crc_q;

	// Decode results
	logic        prev_d;
	logic [2:0]  ones_d;
	logic [7:0]  pbyte_d;
	logic [3:0]  ppos_d;
	logic        open_d;
	logic [7:0]  hb0_d;
	logic [7:0]  hb1_d;
	logic [1:0]  fcnt_d;
	logic [15:0] crc_d;
	res_t        res [2];
	logic [1:0]  nres;

	// Result queue
	res_t             rq_q [RQ_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	assign adv      = s1_valid_q && (cnt_q <= CNT_W'(RQ_DEPTH - 2));
	assign s_tready = !s1_valid_q || adv;
	assign pop      = m_tvalid && m_tready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			line_s1 <= s_tdata;
		end
	end

	// Eight bit steps, oldest bit first
	always_comb begin
		logic        bitv;
		logic        one;
		logic [2:0]  bidx;
		logic [15:0] crc_rel;
		logic [15:0] fcs;
		logic [1:0]  k;

		prev_d  = prev_q;
		ones_d  = ones_q;
		pbyte_d = pbyte_q;
		ppos_d  = ppos_q;
		open_d  = open_q;
		hb0_d   = hb0_q;
		hb1_d   = hb1_q;
		fcnt_d  = fcnt_q;
		crc_d   = crc_q;
		nres    = 2'd0;
		res[0]  = '0;
		res[1]  = '0;
		fcs     = '0;
		k       = KIND_BAD;
		// At most one byte is released per item, always the stored oldest one
		crc_rel = crc_byte(crc_q, hb0_q);

		for (int j = 0; j < 8; j++) begin
			bidx   = 3'(7 - j);
			bitv   = line_s1[bidx];
			one    = (bitv == prev_d);
			prev_d = bitv;

			if (ones_d == STUFF_RUN && !one) begin
				// stuffed zero
				ones_d = 3'd0;
			end else if (ones_d == FLAG_RUN && !one) begin
				// flag: close frame, open a new one
				if (open_d && fcnt_d != 2'd0) begin
					fcs = ~crc_d;
					k   = KIND_BAD;
					if (fcnt_d == 2'd3 && hb0_d == fcs[7:0] && hb1_d == fcs[15:8]) begin
						k = KIND_GOOD;
					end
					if (nres != 2'd2) begin
						res[nres[0]] = '{last: 1'b0, kind: k, data: 8'd0};
						nres         = nres + 2'd1;
					end
				end
				open_d  = 1'b1;
				fcnt_d  = 2'd0;
				crc_d   = CRC_INIT;
				pbyte_d = 8'd0;
				ppos_d  = 4'd0;
				ones_d  = 3'd0;
			end else begin
				if (ones_d == FLAG_RUN) begin
					// seventh one: abort
					if (open_d && fcnt_d != 2'd0 && nres != 2'd2) begin
						res[nres[0]] = '{last: 1'b0, kind: KIND_ABORT, data: 8'd0};
						nres         = nres + 2'd1;
					end
					open_d  = 1'b0;
					fcnt_d  = 2'd0;
					crc_d   = CRC_INIT;
					pbyte_d = 8'd0;
					ppos_d  = 4'd0;
					ones_d  = 3'd0;
				end
				ones_d = one ? (ones_d + 3'd1) : 3'd0;

				if (open_d) begin
					// pack LSB first
					pbyte_d[ppos_d[2:0]] = pbyte_d[ppos_d[2:0]] | one;
					ppos_d = ppos_d + 4'd1;
					if (ppos_d == 4'd8) begin
						if (fcnt_d[1]) begin
							crc_d = crc_rel;
							if (nres != 2'd2) begin
								res[nres[0]] = '{last: 1'b0, kind: KIND_DATA, data: hb0_d};
								nres         = nres + 2'd1;
							end
						end
						hb0_d = hb1_d;
						hb1_d = pbyte_d;
						if (fcnt_d != 2'd3) begin
							fcnt_d = fcnt_d + 2'd1;
						end
						pbyte_d = 8'd0;
						ppos_d  = 4'd0;
					end
				end
			end
		end

		// mark the final result of this item
		if (nres == 2'd1) begin
			res[0].last = 1'b1;
		end else if (nres == 2'd2) begin
			res[1].last = 1'b1;
		end
	end

	// Decoder state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= 1'b0;
			ones_q  <= 3'd0;
			pbyte_q <= 8'd0;
			ppos_q  <= 4'd0;
			open_q  <= 1'b0;
			fcnt_q  <= 2'd0;
			crc_q   <= CRC_INIT;
		end else if (adv) begin
			prev_q  <= prev_d;
			ones_q  <= ones_d;
			pbyte_q <= pbyte_d;
			ppos_q  <= ppos_d;
			open_q  <= open_d;
			fcnt_q  <= fcnt_d;
			crc_q   <= crc_d;
		end
	end

	// Holdback bytes, valid once the frame has written them
	always_ff @(posedge clk) begin
		if (adv) begin
			hb0_q <= hb0_d;
			hb1_q <= hb1_d;
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		if (adv && nres != 2'd0) begin
			rq_q[wr_q] <= res[0];
		end
		if (adv && nres == 2'd2) begin
			rq_q[wr_q + PTR_W'(1)] <= res[1];
		end
	end

	// Result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (adv) begin
				wr_q <= wr_q + PTR_W'(nres);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + (adv ? CNT_W'(nres) : CNT_W'(0)) - CNT_W'(pop);
		end
	end

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = rq_q[rd_q].data;
	assign m_tuser  = rq_q[rd_q].kind;
	assign m_tlast  = rq_q[rd_q].last;

endmodule

// File: src/hdlc_chk.sv
// ----------------------------------------------------------------------------
// HDLC deframer port checker
// Watches the top-level ports for result ordering and payload rules.
// ----------------------------------------------------------------------------
module hdlc_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [1:0] m_tuser,
	input logic       m_tlast
);
	import hdlc_pkg::*;

	// a waiting input item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("waiting input item changed");

	// status results carry no byte
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_DATA |-> m_tdata == 8'd0)
		else $error("status result with nonzero data byte");

	// nothing follows a frame status within one item
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_DATA |-> m_tlast)
		else $error("status result not marked last");

	// the rest of an item's results is queued together with the first
	a_item_whole: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside the results of one item");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=>
			m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("stalled result changed");

endmodule

bind hdlc_nrzi_deframer_crc16 hdlc_chk u_hdlc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
